[hdl/bmh_pkg.sv]
package bmh_pkg;

    localparam int KEY_W            = 32;
    localparam int COUNT_W          = 7;
    localparam int STATUS_W         = 2;
    localparam int DEFAULT_CAPACITY = 127;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic              op;
        logic signed [KEY_W-1:0] key_in;
    } t_in_beat;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] removed_key;
        logic [COUNT_W-1:0]      entry_count;
        logic signed [KEY_W-1:0] top_key;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_LAST,
        S_DOWN,
        S_PUT,
        S_DONE
    } t_state;

endpackage

[hdl/bmh_store.sv]
module bmh_store
    import bmh_pkg::*;
#(
    parameter int DEPTH  = DEFAULT_CAPACITY + 2,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [KEY_W-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [KEY_W-1:0]  o_rdata_a,
    output logic [KEY_W-1:0]  o_rdata_b
);

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rdata_a;
    logic [KEY_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[hdl/binary_max_heap.sv]
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+-----------------------
// input    | i_in_valid  | o_in_stall  | i_in_beat  (t_in_beat)
// output   | o_out_valid | i_out_stall | o_out_beat (t_out_beat)
//
// one beat at a time; the sift loop does one heap level per cycle, bound by
// the registered read of the heap memory
// insert passes S_UP and S_DONE, remove S_LAST, S_DOWN and S_DONE, with S_PUT
// when the key climbs to the root or sinks to a leaf; a first insert or a remove that
// leaves at most one key skips the sift states
// reset clears the state, the count and the output valid only; the memory needs no clearing pass
// a result waits in the output register while the next beat is taken

module binary_max_heap
    import bmh_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int DEPTH = CAPACITY + 2;
    localparam int AW    = $clog2(DEPTH);

    t_state                r_state, n_state;
    logic [CW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_count, n_count;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [KEY_W-1:0]      r_top, n_top;
    logic [KEY_W-1:0]      r_removed, n_removed;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic                  r_ovalid, n_ovalid;
    t_out_beat             r_obeat, n_obeat;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [KEY_W-1:0]      mem_wdata;
    logic [AW-1:0]         mem_raddr_a;
    logic [AW-1:0]         mem_raddr_b;
    logic [KEY_W-1:0]      mem_rdata_a;
    logic [KEY_W-1:0]      mem_rdata_b;

    logic                  in_accept;
    logic [CW-1:0]         count_inc;
    logic [CW:0]           left_pos;
    logic [CW:0]           right_pos;
    logic                  take_right;
    logic [CW:0]           pick_pos;
    logic [KEY_W-1:0]      pick_val;
    logic [CW:0]           next_left;

    bmh_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign count_inc = r_count + CW'(1);

    assign left_pos   = {r_pos, 1'b0};
    assign right_pos  = {r_pos, 1'b1};
    assign take_right = (right_pos <= {1'b0, r_count}) &&
                        ($signed(mem_rdata_b) > $signed(mem_rdata_a));
    assign pick_pos   = take_right ? right_pos : left_pos;
    assign pick_val   = take_right ? mem_rdata_b : mem_rdata_a;
    assign next_left  = {pick_pos[CW-1:0], 1'b0};

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_count     = r_count;
        n_key       = r_key;
        n_removed   = r_removed;
        n_status    = r_status;
        n_ovalid    = r_ovalid;
        n_obeat     = r_obeat;
        mem_we      = 1'b0;
        mem_waddr   = AW'(r_pos);
        mem_wdata   = r_key;
        mem_raddr_a = AW'(r_pos >> 1);
        mem_raddr_b = AW'(right_pos);

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_removed = '0;
                    n_status  = ST_OK;
                    if (i_in_beat.op == OP_INSERT) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_count     = count_inc;
                            n_pos       = count_inc;
                            n_key       = i_in_beat.key_in;
                            mem_raddr_a = AW'(count_inc >> 1);
                            if (count_inc == CW'(1)) begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(1);
                                mem_wdata = i_in_beat.key_in;
                                n_state   = S_DONE;
                            end else begin
                                n_state = S_UP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_removed   = r_top;
                            n_count     = r_count - CW'(1);
                            n_pos       = CW'(1);
                            mem_raddr_a = AW'(r_count);
                            n_state     = S_LAST;
                        end
                    end
                end
            end
            S_UP: begin
                mem_we = 1'b1;
                if ($signed(r_key) > $signed(mem_rdata_a)) begin
                    mem_wdata   = mem_rdata_a;
                    n_pos       = r_pos >> 1;
                    mem_raddr_a = AW'(r_pos >> 2);
                    if ((r_pos >> 1) == CW'(1)) begin
                        n_state = S_PUT;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LAST: begin
                n_key       = mem_rdata_a;
                mem_raddr_a = AW'(2);
                mem_raddr_b = AW'(3);
                if (r_count < CW'(2)) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(1);
                    mem_wdata = mem_rdata_a;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_DOWN;
                end
            end
            S_DOWN: begin
                mem_we = 1'b1;
                if ($signed(pick_val) > $signed(r_key)) begin
                    mem_wdata   = pick_val;
                    n_pos       = pick_pos[CW-1:0];
                    mem_raddr_a = AW'(next_left);
                    mem_raddr_b = AW'(next_left | (CW+1)'(1));
                    if (next_left > {1'b0, r_count}) begin
                        n_state = S_PUT;
                    end
                end else begin
                    n_state = S_DONE;
                end
            end
            S_PUT: begin
                mem_we  = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid                = 1'b1;
                    n_obeat.status          = r_status;
                    n_obeat.removed_key     = r_removed;
                    n_obeat.entry_count     = COUNT_W'(r_count);
                    n_obeat.top_key         = (r_count != '0) ? r_top : '0;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_top = r_top;
        if (mem_we && (mem_waddr == AW'(1))) begin
            n_top = mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_key     <= n_key;
        r_top     <= n_top;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_obeat   <= n_obeat;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_beat  = r_obeat;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("heap count beyond capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_beat.op == OP_INSERT && r_count < CW'(CAPACITY))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted insert did not grow the heap");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status == ST_FULL)
        |-> (o_out_beat.entry_count == COUNT_W'(CAPACITY)))
        else $error("full status with heap not at capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status == ST_EMPTY)
        |-> (o_out_beat.entry_count == '0 && o_out_beat.removed_key == '0))
        else $error("empty status with keys held");

endmodule

[test/tb_binary_max_heap.sv]
`timescale 1ns / 100ps

module tb_binary_max_heap;
    import bmh_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;

    binary_max_heap dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    logic signed [KEY_W-1:0] heap_model [0:DEFAULT_CAPACITY];
    int        model_count = 0;
    t_out_beat expected_results [$];
    int        errors = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;
    int        n_insert = 0;
    int        n_full = 0;
    int        n_remove = 0;
    int        n_empty = 0;
    int        deepest = 0;

    int        stall_mode = 0;
    int        mode_left = 0;
    int        run_left = 0;
    logic      run_level = 1'b0;

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic void swap_entries(input int a, input int b);
        logic signed [KEY_W-1:0] tmp;
        tmp = heap_model[a];
        heap_model[a] = heap_model[b];
        heap_model[b] = tmp;
    endfunction

    function automatic t_out_beat heap_step(input t_in_beat beat);
        t_out_beat res;
        int        pos;
        int        pick;
        bit        moving;
        res = '0;
        res.status = ST_OK;
        moving = 1'b1;
        if (beat.op == OP_INSERT) begin
            n_insert++;
            if (model_count >= DEFAULT_CAPACITY) begin
                res.status = ST_FULL;
                n_full++;
            end else begin
                model_count++;
                heap_model[model_count] = beat.key_in;
                pos = model_count;
                while (moving && pos > 1) begin
                    if (heap_model[pos] > heap_model[pos / 2]) begin
                        swap_entries(pos, pos / 2);
                        pos = pos / 2;
                    end else begin
                        moving = 1'b0;
                    end
                end
            end
        end else begin
            n_remove++;
            if (model_count == 0) begin
                res.status = ST_EMPTY;
                n_empty++;
            end else begin
                res.removed_key = heap_model[1];
                heap_model[1] = heap_model[model_count];
                model_count--;
                pos = 1;
                while (moving && 2 * pos <= model_count) begin
                    pick = 2 * pos;
                    if (pick + 1 <= model_count && heap_model[pick + 1] > heap_model[pick])
                        pick++;
                    if (heap_model[pick] > heap_model[pos]) begin
                        swap_entries(pos, pick);
                        pos = pick;
                    end else begin
                        moving = 1'b0;
                    end
                end
            end
        end
        if (model_count > deepest)
            deepest = model_count;
        res.entry_count = COUNT_W'(model_count);
        res.top_key = (model_count > 0) ? heap_model[1] : '0;
        return res;
    endfunction

    function automatic logic signed [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2, 3, 4: return $signed(32'($urandom_range(0, 8))) - 32'sd4;
            default: return $signed(32'($urandom));
        endcase
    endfunction

    task automatic send_beat(input logic op, input logic signed [KEY_W-1:0] key);
        int gap;
        in_valid <= 1'b1;
        in_beat <= '{op: op, key_in: key};
        do @(posedge clk); while (in_stall);
        expected_results.push_back(heap_step(in_beat));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [KEY_W-1:0] got,
                                 input logic [KEY_W-1:0] want);
        if (got !== want) begin
            $display("mismatch %s: got %0d expected %0d", name, $signed(got), $signed(want));
            errors++;
        end
    endtask

    task automatic test_empty_remove();
        send_beat(OP_REMOVE, '0);
        send_beat(OP_REMOVE, 32'shffffffff);
        send_beat(OP_INSERT, 32'sd17);
        send_beat(OP_REMOVE, 32'sh12345678);
        send_beat(OP_REMOVE, '0);
        wait_drain();
    endtask

    task automatic test_key_extremes();
        send_beat(OP_INSERT, 32'sh80000000);
        send_beat(OP_INSERT, 32'sh7fffffff);
        send_beat(OP_INSERT, 32'sd0);
        send_beat(OP_INSERT, -32'sd1);
        send_beat(OP_INSERT, 32'sd1);
        repeat (5) send_beat(OP_REMOVE, rand_key());
        wait_drain();
    endtask

    task automatic test_equal_keys();
        send_beat(OP_INSERT, 32'sd9);
        send_beat(OP_INSERT, 32'sd7);
        send_beat(OP_INSERT, 32'sd7);
        send_beat(OP_INSERT, 32'sd1);
        send_beat(OP_INSERT, 32'sd9);
        send_beat(OP_INSERT, 32'sd7);
        repeat (6) send_beat(OP_REMOVE, '0);
        wait_drain();
    endtask

    task automatic test_fill_to_capacity();
        while (model_count < DEFAULT_CAPACITY) send_beat(OP_INSERT, rand_key());
        repeat (3) send_beat(OP_INSERT, rand_key());
        send_beat(OP_REMOVE, '0);
        send_beat(OP_INSERT, rand_key());
        send_beat(OP_INSERT, rand_key());
        while (model_count > 0) send_beat(OP_REMOVE, rand_key());
        send_beat(OP_REMOVE, rand_key());
        wait_drain();
    endtask

    task automatic test_random_mix();
        int bias;
        for (int seg = 0; seg < 10; seg++) begin
            bias = $urandom_range(15, 85);
            repeat (25) begin
                if ($urandom_range(0, 99) < bias)
                    send_beat(OP_INSERT, rand_key());
                else
                    send_beat(OP_REMOVE, rand_key());
            end
            if ($urandom_range(0, 1) == 0)
                wait_drain();
        end
        wait_drain();
    endtask

    // receiver stall pattern: free running, random, or long runs
    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(64, 256);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            default: begin
                if (run_left == 0) begin
                    run_level = ~run_level;
                    run_left = $urandom_range(1, 20);
                end else begin
                    run_left--;
                end
                out_stall <= run_level;
            end
        endcase
    end

    always @(posedge clk) begin
        t_out_beat want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result beat: status %0d count %0d",
                         out_beat.status, out_beat.entry_count);
                errors++;
            end else begin
                want = expected_results.pop_front();
                compare_field("status", KEY_W'(out_beat.status), KEY_W'(want.status));
                compare_field("removed_key", out_beat.removed_key, want.removed_key);
                compare_field("entry_count", KEY_W'(out_beat.entry_count),
                              KEY_W'(want.entry_count));
                compare_field("top_key", out_beat.top_key, want.top_key);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_remove();
        test_key_extremes();
        test_equal_keys();
        test_fill_to_capacity();
        test_random_mix();
        test_fill_to_capacity();
        wait_drain();
        repeat (20) @(posedge clk);
        $display("covered %0d inserts (%0d refused when full), %0d removes (%0d on empty)",
                 n_insert, n_full, n_remove, n_empty);
        $display("heap reached %0d of %0d entries", deepest, DEFAULT_CAPACITY);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
hdl/bmh_pkg.sv
hdl/bmh_store.sv
hdl/binary_max_heap.sv
test/tb_binary_max_heap.sv
